// ----- sv/rwpt_pkg.sv -----
// ----------------------------------------------------------------------------
// rwpt_pkg
// Shared constants for the white point tonemap pipeline.
// ----------------------------------------------------------------------------
package rwpt_pkg;
	localparam int CH_NUM     = 3;      // red, green, blue
	localparam int IN_W       = 16;     // input sample width
	localparam int OUT_W      = 8;      // output sample width
	localparam int IN_INT_SH  = 12;     // input is Q4.12 before alignment to F
	localparam int IWS_W      = 16;     // inv_white_squared, Q0.16
	localparam int OUT_SCALE  = 255;
	localparam logic [IWS_W-1:0] IWS_RESET = 16'd16384;
endpackage

// ----- sv/rwpt_lum.sv -----
// ----------------------------------------------------------------------------
// rwpt_lum
// Luminance, Reinhard numerator/denominator and per channel dividend.
// Five register stages.
// ----------------------------------------------------------------------------
module rwpt_lum import rwpt_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             ce,
	input  logic                             in_valid,
	input  logic [CH_NUM*IN_W-1:0]           pix,
	input  logic [IWS_W-1:0]                 iws,
	output logic                             out_valid,
	output logic [2*FRAC_BITS+10-1:0]        dvd [CH_NUM],
	output logic [FRAC_BITS+6-1:0]           den
);
	localparam int XW  = FRAC_BITS + 4;
	localparam int LW  = FRAC_BITS + 5;
	localparam int NW  = FRAC_BITS + 6;
	localparam int PW  = FRAC_BITS + XW;
	localparam int DVW = XW + NW;
	localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;
	localparam logic [FRAC_BITS-1:0] WR = FRAC_BITS'((2126 * ONE_L + 5000) / 10000);
	localparam logic [FRAC_BITS-1:0] WG = FRAC_BITS'((7152 * ONE_L + 5000) / 10000);
	localparam logic [FRAC_BITS-1:0] WB = FRAC_BITS'((722 * ONE_L + 5000) / 10000);
	localparam logic [NW-1:0] ONE = NW'(ONE_L);

	logic [4:0]          v_q;
	logic [XW-1:0]       x_s1 [CH_NUM];
	logic [XW-1:0]       x_s2 [CH_NUM];
	logic [XW-1:0]       x_s3 [CH_NUM];
	logic [XW-1:0]       x_s4 [CH_NUM];
	logic [PW-1:0]       pr_s1 [CH_NUM];
	logic [LW-1:0]       lum_s2;
	logic [LW+IWS_W-1:0] lw_s3;
	logic [NW-1:0]       den_s3, den_s4, den_s5;
	logic [NW-1:0]       num_s4;
	logic [DVW-1:0]      dvd_s5 [CH_NUM];
	logic [PW+1:0]       sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (ce) begin
			v_q <= {v_q[3:0], in_valid};
		end
	end

	assign sum = (PW+2)'(pr_s1[0]) + (PW+2)'(pr_s1[1]) + (PW+2)'(pr_s1[2]);

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int c = 0; c < CH_NUM; c++) begin
				x_s1[c] <= XW'(pix[c*IN_W +: IN_W]) << (FRAC_BITS - IN_INT_SH);
				x_s2[c] <= x_s1[c];
				x_s3[c] <= x_s2[c];
				x_s4[c] <= x_s3[c];
				dvd_s5[c] <= DVW'(x_s4[c]) * DVW'(num_s4);
			end
			pr_s1[0] <= PW'(XW'(pix[0 +: IN_W]) << (FRAC_BITS - IN_INT_SH)) * PW'(WR);
			pr_s1[1] <= PW'(XW'(pix[IN_W +: IN_W]) << (FRAC_BITS - IN_INT_SH)) * PW'(WG);
			pr_s1[2] <= PW'(XW'(pix[2*IN_W +: IN_W]) << (FRAC_BITS - IN_INT_SH)) * PW'(WB);
			lum_s2 <= LW'(sum >> FRAC_BITS);
			lw_s3  <= (LW+IWS_W)'(lum_s2) * (LW+IWS_W)'(iws);
			den_s3 <= ONE + NW'(lum_s2);
			num_s4 <= ONE + NW'(lw_s3 >> IWS_W);
			den_s4 <= den_s3;
			den_s5 <= den_s4;
		end
	end

	assign out_valid = v_q[4];
	assign dvd = dvd_s5;
	assign den = den_s5;
endmodule

// ----- sv/rwpt_div.sv -----
// ----------------------------------------------------------------------------
// rwpt_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rwpt_div #(
	parameter int NW = 30,   // dividend width
	parameter int DW = 22,   // divisor width
	parameter int QW = 20    // quotient width, quotient known to fit
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          ce,
	input  logic          in_valid,
	input  logic [NW-1:0] dvd,
	input  logic [DW-1:0] dvs,
	output logic          out_valid,
	output logic [QW-1:0] quo
);
	localparam int AW = DW + 1 + QW;

	logic [AW-1:0] acc_s [QW+1];
	logic [DW-1:0] dvs_s [QW+1];
	logic [QW:0]   v_s;

	assign acc_s[0] = AW'(dvd);
	assign dvs_s[0] = dvs;
	assign v_s[0]   = in_valid;

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [AW-1:0] sh;
		logic [DW:0]   hi;
		logic          ge;
		assign sh = acc_s[i] << 1;
		assign hi = sh[AW-1:QW];
		assign ge = hi >= {1'b0, dvs_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (ce) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				dvs_s[i+1] <= dvs_s[i];
				if (ge) begin
					acc_s[i+1] <= {hi - {1'b0, dvs_s[i]}, sh[QW-1:1], 1'b1};
				end else begin
					acc_s[i+1] <= sh;
				end
			end
		end
	end

	assign out_valid = v_s[QW];
	assign quo = acc_s[QW][QW-1:0];
endmodule

// ----- sv/rwpt_sqrt.sv -----
// ----------------------------------------------------------------------------
// rwpt_sqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rwpt_sqrt #(
	parameter int RW = 18    // root width; radicand is 2*RW bits
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            ce,
	input  logic            in_valid,
	input  logic [2*RW-1:0] rad,
	output logic            out_valid,
	output logic [RW-1:0]   root
);
	localparam int MW = RW + 2;

	logic [MW-1:0]   rem_s  [RW+1];
	logic [2*RW-1:0] bits_s [RW+1];
	logic [RW-1:0]   root_s [RW+1];
	logic [RW:0]     v_s;

	assign rem_s[0]  = '0;
	assign bits_s[0] = rad;
	assign root_s[0] = '0;
	assign v_s[0]    = in_valid;

	for (genvar i = 0; i < RW; i++) begin : g_stage
		logic [MW-1:0] cur;
		logic [MW-1:0] trial;
		assign cur   = {rem_s[i][MW-3:0], bits_s[i][2*RW-1 -: 2]};
		assign trial = {root_s[i], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (ce) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				bits_s[i+1] <= bits_s[i] << 2;
				if (cur >= trial) begin
					rem_s[i+1]  <= cur - trial;
					root_s[i+1] <= {root_s[i][RW-2:0], 1'b1};
				end else begin
					rem_s[i+1]  <= cur;
					root_s[i+1] <= {root_s[i][RW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_s[RW];
	assign root = root_s[RW];
endmodule

// ----- sv/reinhard_white_point_tonemap_core.sv -----
// ----------------------------------------------------------------------------
// reinhard_white_point_tonemap_core
// Extended Reinhard luminance tonemap with programmable white point and
// square root gamma, 16-bit RGB in, 8-bit RGB out.
// ----------------------------------------------------------------------------
// Pipeline: 5 luminance stages, FRAC_BITS+4 divider stages,
// FRAC_BITS+2 square root stages and 1 output stage.
// Throughput: one pixel per cycle; the whole pipeline holds on output stall.
// Reset: arst_n clears all valid bits and loads inv_white_squared with 0.25.
module reinhard_white_point_tonemap_core import rwpt_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // red_in, green_in, blue_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data        // inv_white_squared
);
	localparam int XW  = FRAC_BITS + 4;
	localparam int NW  = FRAC_BITS + 6;
	localparam int DVW = XW + NW;
	localparam int RW  = FRAC_BITS + 2;
	localparam int MPW = RW + 8;

	logic               ce;
	logic [IWS_W-1:0]   iws_q;
	logic               lum_v;
	logic [DVW-1:0]     dvd [CH_NUM];
	logic [NW-1:0]      den;
	logic [CH_NUM-1:0]  div_v, sq_v;
	logic [XW-1:0]      y [CH_NUM];
	logic [RW-1:0]      r [CH_NUM];
	logic               out_v_q;
	logic [CH_NUM*OUT_W-1:0] out_q;

	assign ce            = !out_v_q || m_axis_tready;
	assign s_axis_tready = ce;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iws_q <= IWS_RESET;
		end else if (cfg_valid) begin
			iws_q <= cfg_data;
		end
	end

	rwpt_lum #(.FRAC_BITS(FRAC_BITS)) u_lum (
		.clk, .arst_n, .ce,
		.in_valid (s_axis_tvalid),
		.pix      (s_axis_tdata),
		.iws      (iws_q),
		.out_valid(lum_v),
		.dvd      (dvd),
		.den      (den)
	);

	for (genvar c = 0; c < CH_NUM; c++) begin : g_ch
		rwpt_div #(.NW(DVW), .DW(NW), .QW(XW)) u_div (
			.clk, .arst_n, .ce,
			.in_valid (lum_v),
			.dvd      (dvd[c]),
			.dvs      (den),
			.out_valid(div_v[c]),
			.quo      (y[c])
		);
		rwpt_sqrt #(.RW(RW)) u_sqrt (
			.clk, .arst_n, .ce,
			.in_valid (div_v[c]),
			.rad      ((2*RW)'(y[c]) << FRAC_BITS),
			.out_valid(sq_v[c]),
			.root     (r[c])
		);

		logic [MPW-1:0] prod;
		logic [MPW-1:0] val;
		assign prod = MPW'(r[c]) * MPW'(OUT_SCALE);
		assign val  = prod >> FRAC_BITS;

		always_ff @(posedge clk) begin
			if (ce) begin
				out_q[c*OUT_W +: OUT_W] <= (val > MPW'(OUT_SCALE)) ? OUT_W'(OUT_SCALE)
				                                                   : OUT_W'(val);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (ce) begin
			out_v_q <= sq_v[0];
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;
endmodule
